// ===== hdl/pixelate_cell_average_defines.svh =====
// assertion macros used by the checker
`ifndef PIXELATE_CELL_AVERAGE_DEFINES_SVH
`define PIXELATE_CELL_AVERAGE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define PCA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pixelate port check failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define PCA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pixelate port check failed");

`endif

// ===== hdl/pca_pkg.sv =====
package pca_pkg;

  // frame store geometry
  localparam int unsigned MAX_WIDTH   = 256;
  localparam int unsigned MAX_HEIGHT  = 256;
  localparam int unsigned MAX_CELL    = 128;
  localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int          ADDR_W      = $clog2(STORE_DEPTH);

  // coordinate, cell and accumulator widths
  localparam int XW     = $clog2(MAX_WIDTH + 1);
  localparam int YW     = $clog2(MAX_HEIGHT + 1);
  localparam int XN_W   = $clog2(MAX_WIDTH + MAX_CELL + 1);
  localparam int YN_W   = $clog2(MAX_HEIGHT + MAX_CELL + 1);
  localparam int CS_W   = $clog2(MAX_CELL + 1);
  localparam int CNT_W  = $clog2(MAX_CELL * MAX_CELL + 1);
  localparam int SUM_W  = $clog2(MAX_CELL * MAX_CELL * 255 + 1);

  // pixel layout
  localparam int CH_W     = 8;
  localparam int NUM_CH   = 4;
  localparam int CH_IDX_W = $clog2(NUM_CH);
  localparam int PIX_W    = CH_W * NUM_CH;
  localparam int WORD_W   = PIX_W + 1;

  // divider: quotient is below 2**CH_W, one bit per step
  localparam int STEP_W = $clog2(CH_W);
  localparam int DIV_W  = (SUM_W > CNT_W + CH_W - 1) ? SUM_W : CNT_W + CH_W - 1;

  // configuration registers
  localparam int CELL_SIZE_W = 8;
  localparam int DIM_W       = 9;
  localparam int CFG_DATA_W  = 9;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CELL_SIZE_W-1:0] CELL_SIZE_RST    = CELL_SIZE_W'(4);
  localparam logic [DIM_W-1:0]       IMAGE_WIDTH_RST  = DIM_W'(256);
  localparam logic [DIM_W-1:0]       IMAGE_HEIGHT_RST = DIM_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_SIZE    = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_RUN  = 2'd1,
    KIND_READ = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       pos_x;
    logic [7:0]       pos_y;
    logic [PIX_W-1:0] pixel_in;
    logic             selected;
  } req_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             run_done;
  } res_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [CH_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== hdl/pca_ram.sv =====
module pca_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/pca_div.sv =====
module pca_div
  import pca_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  den_q, den_d;
  logic [CH_W-1:0]   quot_q, quot_d;
  logic              fits;

  assign fits = (rem_q >= den_q);

  // restoring division, msb of the quotient first
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (req_i.start) begin
      rem_d  = DIV_W'(req_i.dividend);
      den_d  = DIV_W'(req_i.divisor) << (CH_W - 1);
      quot_d = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = rem_q - den_q;
      end
      quot_d = {quot_q[CH_W-2:0], fits};
      den_d  = den_q >> 1;
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(CH_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// ===== hdl/pixelate_cell_average.sv =====
// Pixelate engine over a 256 x 256 ARGB frame store with one selection bit per
// pixel. A word is taken at a clock edge with start high and busy low; a load
// word is written in that cycle and busy stays low, so loads go one per cycle.
// A read word raises busy for one cycle; its pixel is read from the store and
// registered into res_o, marked by res_valid_o. A run word walks the
// active image cell by cell and ends with one word carrying run_done. The
// result is shown for exactly one cycle and cannot be held off: sample it
// whenever res_valid_o is high. Run time is set by the single-port store and
// the shared divider: each cell is first scanned to sum its selected pixels,
// then, if any pixel is selected, its four channels are divided in turn and
// each pixel is read back and rewritten where its mask bit is set. Cell size
// 0 or 1, or a zero dimension, skips the walk and gives only the run_done word.
// Reading a pixel never loaded returns undefined data. Configuration may be
// written only while busy is low.
module pixelate_cell_average
  import pca_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req_i,
  output res_t                  res_o,
  output logic                  res_valid_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_RDWAIT = 11'b00000000010,
    S_CELL   = 11'b00000000100,
    S_SCAN   = 11'b00000001000,
    S_DRAIN  = 11'b00000010000,
    S_DIVGO  = 11'b00000100000,
    S_DIV    = 11'b00001000000,
    S_FRD    = 11'b00010000000,
    S_FWR    = 11'b00100000000,
    S_NEXT   = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [CELL_SIZE_W-1:0] cell_size_q;
  logic [DIM_W-1:0]       image_width_q;
  logic [DIM_W-1:0]       image_height_q;

  // cell walker
  logic [XW-1:0]   bx_q, bx_d;
  logic [YW-1:0]   by_q, by_d;
  logic [CS_W-1:0] dx_q, dx_d;
  logic [CS_W-1:0] dy_q, dy_d;
  logic [CS_W-1:0] cw_q, cw_d;
  logic [CS_W-1:0] ch_q, ch_d;

  // per-cell accumulation and averages; index NUM_CH-1 is alpha
  logic [NUM_CH-1:0][SUM_W-1:0] sums_q, sums_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [NUM_CH-1:0][CH_W-1:0]  avg_q, avg_d;
  logic [CH_IDX_W-1:0]          ch_idx_q, ch_idx_d;
  logic                         acc_v_q, acc_v_d;

  // read word and result
  logic rd_in_q, rd_in_d;
  res_t res_q, res_d;
  logic res_valid_q, res_valid_d;

  // saturated geometry
  logic [CS_W-1:0] cs;
  logic [XW-1:0]   w;
  logic [YW-1:0]   h;
  logic            run_skip;

  logic            accept;
  logic            io_inside;
  logic [ADDR_W-1:0] io_addr;
  logic [XW-1:0]   px;
  logic [YW-1:0]   py;
  logic [ADDR_W-1:0] walk_addr;
  logic [XW-1:0]   w_rem;
  logic [YW-1:0]   h_rem;
  logic [XN_W-1:0] bx_nx;
  logic [YN_W-1:0] by_nx;
  logic            last_col;
  logic            last_px;
  logic [CH_IDX_W-1:0] avg_slot;

  // store port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  logic              rd_sel;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  assign cs = (cell_size_q > MAX_CELL) ? CS_W'(MAX_CELL) : CS_W'(cell_size_q);
  assign w  = (32'(image_width_q) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(image_width_q);
  assign h  = (32'(image_height_q) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(image_height_q);
  assign run_skip = (cs <= CS_W'(1)) || (w == '0) || (h == '0);

  // addressing for load and read words
  assign io_inside = (32'(req_i.pos_x) < MAX_WIDTH) && (32'(req_i.pos_y) < MAX_HEIGHT);
  assign io_addr   = ADDR_W'(32'(req_i.pos_y) * MAX_WIDTH + 32'(req_i.pos_x));

  // addressing for the cell walk
  assign px        = bx_q + XW'(dx_q);
  assign py        = by_q + YW'(dy_q);
  assign walk_addr = ADDR_W'(32'(py) * MAX_WIDTH + 32'(px));

  // remaining extent for partial cells at the right and bottom edges
  assign w_rem = w - bx_q;
  assign h_rem = h - by_q;
  assign bx_nx = XN_W'(bx_q) + XN_W'(cs);
  assign by_nx = YN_W'(by_q) + YN_W'(cs);

  assign last_col = (dx_q == cw_q - 1'b1);
  assign last_px  = last_col && (dy_q == ch_q - 1'b1);
  assign avg_slot = CH_IDX_W'(NUM_CH - 1) - ch_idx_q;

  // mask bit rides on top of the stored pixel
  assign rd_sel = ram_rdata[PIX_W];

  assign ram_we    = (accept && (req_i.kind == KIND_LOAD) && io_inside)
                   || ((state_q == S_FWR) && rd_sel);
  assign ram_addr  = (state_q == S_IDLE) ? io_addr : walk_addr;
  assign ram_wdata = (state_q == S_IDLE) ? {req_i.selected, req_i.pixel_in}
                                         : {1'b1, avg_q};

  pca_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // one divider serves all four channels in turn
  assign div_req.start    = (state_q == S_DIVGO) && (cnt_q != '0);
  assign div_req.dividend = sums_q[avg_slot];
  assign div_req.divisor  = cnt_q;

  pca_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d     = state_q;
    bx_d        = bx_q;
    by_d        = by_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    cw_d        = cw_q;
    ch_d        = ch_q;
    sums_d      = sums_q;
    cnt_d       = cnt_q;
    avg_d       = avg_q;
    ch_idx_d    = ch_idx_q;
    rd_in_d     = rd_in_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    acc_v_d     = 1'b0;

    // store read data comes in the cycle after its scan address
    if (acc_v_q && rd_sel) begin
      for (int k = 0; k < NUM_CH; k++) begin
        sums_d[k] = sums_q[k] + SUM_W'(ram_rdata[k*CH_W +: CH_W]);
      end
      cnt_d = cnt_q + 1'b1;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.kind)
            KIND_RUN: begin
              bx_d    = '0;
              by_d    = '0;
              state_d = run_skip ? S_DONE : S_CELL;
            end
            KIND_READ: begin
              rd_in_d = io_inside;
              state_d = S_RDWAIT;
            end
            default: begin
              // loads write in this cycle, unused kind is dropped
            end
          endcase
        end
      end
      S_RDWAIT: begin
        res_d.pixel_out = rd_in_q ? ram_rdata[PIX_W-1:0] : '0;
        res_d.run_done  = 1'b0;
        res_valid_d     = 1'b1;
        state_d         = S_IDLE;
      end
      S_CELL: begin
        cw_d     = (w_rem < XW'(cs)) ? CS_W'(w_rem) : cs;
        ch_d     = (h_rem < YW'(cs)) ? CS_W'(h_rem) : cs;
        dx_d     = '0;
        dy_d     = '0;
        sums_d   = '0;
        cnt_d    = '0;
        ch_idx_d = '0;
        state_d  = S_SCAN;
      end
      S_SCAN: begin
        acc_v_d = 1'b1;
        if (last_col) begin
          dx_d = '0;
          dy_d = dy_q + 1'b1;
        end else begin
          dx_d = dx_q + 1'b1;
        end
        if (last_px) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_DIVGO;
      end
      S_DIVGO: begin
        // empty cell: nothing to average, nothing to write
        state_d = (cnt_q == '0) ? S_NEXT : S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          avg_d[avg_slot] = div_rsp.quot;
          if (ch_idx_q == CH_IDX_W'(NUM_CH - 1)) begin
            dx_d    = '0;
            dy_d    = '0;
            state_d = S_FRD;
          end else begin
            ch_idx_d = ch_idx_q + 1'b1;
            state_d  = S_DIVGO;
          end
        end
      end
      S_FRD: begin
        state_d = S_FWR;
      end
      S_FWR: begin
        // write-back happens through ram_we when the mask bit is set
        if (last_col) begin
          dx_d = '0;
          dy_d = dy_q + 1'b1;
        end else begin
          dx_d = dx_q + 1'b1;
        end
        state_d = last_px ? S_NEXT : S_FRD;
      end
      S_NEXT: begin
        if (bx_nx >= XN_W'(w)) begin
          bx_d = '0;
          if (by_nx >= YN_W'(h)) begin
            state_d = S_DONE;
          end else begin
            by_d    = YW'(by_nx);
            state_d = S_CELL;
          end
        end else begin
          bx_d    = XW'(bx_nx);
          state_d = S_CELL;
        end
      end
      S_DONE: begin
        res_d.pixel_out = '0;
        res_d.run_done  = 1'b1;
        res_valid_d     = 1'b1;
        state_d         = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acc_v_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_v_q     <= acc_v_d;
      res_valid_q <= res_valid_d;
    end
  end

  // configuration registers, writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q    <= CELL_SIZE_RST;
      image_width_q  <= IMAGE_WIDTH_RST;
      image_height_q <= IMAGE_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CELL_SIZE:    cell_size_q    <= cfg_wdata_i[CELL_SIZE_W-1:0];
        REG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata_i[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height_q <= cfg_wdata_i[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    bx_q     <= bx_d;
    by_q     <= by_d;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    cw_q     <= cw_d;
    ch_q     <= ch_d;
    sums_q   <= sums_d;
    cnt_q    <= cnt_d;
    avg_q    <= avg_d;
    ch_idx_q <= ch_idx_d;
    rd_in_q  <= rd_in_d;
    res_q    <= res_d;
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

// ===== hdl/pca_checker.sv =====
`include "pixelate_cell_average_defines.svh"

module pca_checker
  import pca_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input res_t res_o,
  input logic res_valid_o
);

  logic rd_acc;
  logic ld_acc;

  assign rd_acc = rst_ni && start && !busy && (req_i.kind == KIND_READ);
  assign ld_acc = rst_ni && start && !busy && (req_i.kind == KIND_LOAD);

  // a word is only shown once the engine is free again
  `PCA_ASSERT_IMPL(a_word_when_free, res_valid_o, !busy)
  // no two words back to back
  `PCA_ASSERT_NEXT(a_word_single, res_valid_o, !res_valid_o)
  // read data follows each read word and is not a run word
  `PCA_ASSERT_IMPL(a_read_latency, $past(rd_acc, 2), res_valid_o && !res_o.run_done)
  // a load neither blocks nor answers
  `PCA_ASSERT_NEXT(a_load_quiet, ld_acc, !busy && !res_valid_o)
  // the run word carries no pixel
  `PCA_ASSERT_IMPL(a_run_word_zero, res_valid_o && res_o.run_done, res_o.pixel_out == '0)

endmodule

bind pixelate_cell_average pca_checker u_pca_checker (.*);
